// ===== src/tjpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tjpq_pkg - shared definitions for the timed job priority queue
// Field widths, command and status codes, the stored entry layout and the
// control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tjpq_pkg;

  // default number of queue slots
  localparam int QUEUE_DEPTH_DEF = 16;

  // field widths
  localparam int CMD_W   = 3;
  localparam int TAG_W   = 16;
  localparam int PRI_W   = 8;
  localparam int SEC_W   = 32;
  localparam int NSEC_W  = 30;
  localparam int BYTES_W = 16;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 5;
  localparam int TOTAL_W = 20;
  localparam int NEW_W   = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TIME_INS = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRIO_INS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_RET  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // one stored job
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [PRI_W-1:0]   prio;
    logic [SEC_W-1:0]   sec;
    logic [NSEC_W-1:0]  nsec;
    logic [BYTES_W-1:0] nbytes;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              search_init;
    logic              search_step;
    logic              shift_init;
    logic              shift_step;
    logic              write_new;
    logic              pop_read;
    logic              pop_commit;
    logic              set_status;
    logic [STAT_W-1:0] status_val;
    logic              load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             full;
    logic             empty;
    logic             search_done;
    logic             shift_done;
    logic             out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/tjpq_ram.sv =====
// ----------------------------------------------------------------------------
// tjpq_ram - generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module tjpq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/tjpq_datapath.sv =====
// ----------------------------------------------------------------------------
// tjpq_datapath - entry storage, bookkeeping and result register
// Entries live in a ring buffer in RAM. The logical index walks through it
// one entry per cycle for the slot search and for the shift that opens a
// slot; counters track depth, total bytes and new jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module tjpq_datapath #(
  parameter int QUEUE_DEPTH = tjpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tjpq_pkg::ctrl_cmd_t               ctl,
  output tjpq_pkg::dp_stat_t                     stat,
  input  wire logic [tjpq_pkg::CMD_W-1:0]        command,
  input  wire logic [tjpq_pkg::TAG_W-1:0]        job_tag,
  input  wire logic [tjpq_pkg::PRI_W-1:0]        job_priority,
  input  wire logic [tjpq_pkg::SEC_W-1:0]        wake_sec,
  input  wire logic [tjpq_pkg::NSEC_W-1:0]       wake_nanosec,
  input  wire logic [tjpq_pkg::BYTES_W-1:0]      job_bytes,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic      [tjpq_pkg::STAT_W-1:0]       status,
  output logic      [tjpq_pkg::TAG_W-1:0]        out_tag,
  output logic      [tjpq_pkg::PRI_W-1:0]        out_priority,
  output logic      [tjpq_pkg::SEC_W-1:0]        out_sec,
  output logic      [tjpq_pkg::NSEC_W-1:0]       out_nanosec,
  output logic      [tjpq_pkg::BYTES_W-1:0]      out_bytes,
  output logic      [tjpq_pkg::DEPTH_W-1:0]      queue_depth,
  output logic      [tjpq_pkg::TOTAL_W-1:0]      queue_bytes,
  output logic      [tjpq_pkg::NEW_W-1:0]        new_jobs
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = CW + 1;

  // ring position of logical index k
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] k);
    logic [PW-1:0] sum;
    sum = PW'(hd) + {1'b0, k};
    if (sum >= PW'(QUEUE_DEPTH)) begin
      sum = sum - PW'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // captured word and bookkeeping
  logic [tjpq_pkg::CMD_W-1:0]   cmd;
  tjpq_pkg::entry_t             item;
  logic [IW-1:0]                head;
  logic [CW-1:0]                count;
  logic [tjpq_pkg::TOTAL_W-1:0] total;
  logic [CW-1:0]                newcnt;
  logic [CW-1:0]                rd_idx;
  logic [CW-1:0]                rd_pidx;
  logic                         rd_pend;
  logic [CW-1:0]                rem;
  logic [CW-1:0]                pos;
  logic [tjpq_pkg::STAT_W-1:0]  res_status;
  logic                         res_pop;

  // RAM ports
  tjpq_pkg::entry_t rdata;
  tjpq_pkg::entry_t wdata;
  logic             we;
  logic             re;
  logic [IW-1:0]    waddr;
  logic [IW-1:0]    raddr;

  tjpq_ram #(
    .WIDTH ($bits(tjpq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(IW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // slot compare against the entry now on the read port
  logic later;
  logic match;
  logic hit;
  logic [CW-1:0] found_pos;
  logic [CW-1:0] shift_pos;

  always_comb begin
    later = (rdata.sec > item.sec) || ((rdata.sec == item.sec) && (rdata.nsec > item.nsec));
    if (cmd == tjpq_pkg::CMD_PRIO_INS) begin
      match = (rdata.prio > item.prio) || ((rdata.prio == item.prio) && later);
    end else begin
      match = later;
    end
    hit       = rd_pend && match;
    found_pos = hit ? rd_pidx : count;
    shift_pos = (cmd == tjpq_pkg::CMD_APPEND) ? count : found_pos;
  end

  // RAM access selection
  always_comb begin
    re    = ctl.pop_read
          || (ctl.search_step && (rd_idx != count))
          || (ctl.shift_step && (rem != '0));
    raddr = ctl.pop_read ? head : phys(head, rd_idx);
    we    = ctl.write_new || (ctl.shift_step && rd_pend);
    waddr = ctl.write_new ? phys(head, pos) : phys(head, CW'(rd_pidx + CW'(1)));
    wdata = ctl.write_new ? item : rdata;
  end

  // status to controller
  always_comb begin
    stat.command     = cmd;
    stat.full        = (count == CW'(QUEUE_DEPTH));
    stat.empty       = (count == '0);
    stat.search_done = hit || (rd_idx == count);
    stat.shift_done  = (rem == '0) && !rd_pend;
    stat.out_busy    = out_valid && !out_ready;
  end

  // captured word, walk registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd         <= command;
      item.tag    <= job_tag;
      item.prio   <= job_priority;
      item.sec    <= wake_sec;
      item.nsec   <= wake_nanosec;
      item.nbytes <= job_bytes;
    end
    if (ctl.search_init) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else if (ctl.search_step) begin
      rd_pend <= (rd_idx != count);
      rd_pidx <= rd_idx;
      if (rd_idx != count) begin
        rd_idx <= CW'(rd_idx + CW'(1));
      end
    end else if (ctl.shift_init) begin
      pos     <= shift_pos;
      rem     <= CW'(count - shift_pos);
      rd_idx  <= CW'(count - CW'(1));
      rd_pend <= 1'b0;
    end else if (ctl.shift_step) begin
      rd_pend <= (rem != '0);
      rd_pidx <= rd_idx;
      if (rem != '0) begin
        rem    <= CW'(rem - CW'(1));
        rd_idx <= CW'(rd_idx - CW'(1));
      end
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      total      <= '0;
      newcnt     <= '0;
      res_status <= tjpq_pkg::ST_OK;
      res_pop    <= 1'b0;
    end else begin
      if (ctl.capture) begin
        res_status <= tjpq_pkg::ST_OK;
        res_pop    <= 1'b0;
      end
      if (ctl.set_status) begin
        res_status <= ctl.status_val;
      end
      if (ctl.write_new) begin
        count <= CW'(count + CW'(1));
        total <= tjpq_pkg::TOTAL_W'(total + tjpq_pkg::TOTAL_W'(item.nbytes));
        if ((cmd == tjpq_pkg::CMD_PRIO_INS) && (newcnt != CW'(QUEUE_DEPTH))) begin
          newcnt <= CW'(newcnt + CW'(1));
        end
      end
      if (ctl.pop_commit) begin
        head    <= phys(head, CW'(1));
        count   <= CW'(count - CW'(1));
        total   <= tjpq_pkg::TOTAL_W'(total - tjpq_pkg::TOTAL_W'(rdata.nbytes));
        res_pop <= 1'b1;
        if ((cmd == tjpq_pkg::CMD_POP_RET) && (newcnt != '0)) begin
          newcnt <= CW'(newcnt - CW'(1));
        end
      end
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word; popped fields are zero unless a pop succeeded
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status       <= res_status;
      out_tag      <= res_pop ? rdata.tag    : '0;
      out_priority <= res_pop ? rdata.prio   : '0;
      out_sec      <= res_pop ? rdata.sec    : '0;
      out_nanosec  <= res_pop ? rdata.nsec   : '0;
      out_bytes    <= res_pop ? rdata.nbytes : '0;
      queue_depth  <= tjpq_pkg::DEPTH_W'(count);
      queue_bytes  <= total;
      new_jobs     <= tjpq_pkg::NEW_W'(newcnt);
    end
  end

endmodule

`default_nettype wire

// ===== src/tjpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tjpq_ctrl - command sequencer for the timed job priority queue
// Decodes each accepted word and steps the datapath through search, shift,
// write or pop, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tjpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tjpq_pkg::dp_stat_t stat,
  output tjpq_pkg::ctrl_cmd_t     ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_insert;
  logic       is_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command class
  always_comb begin
    is_insert = (stat.command == tjpq_pkg::CMD_TIME_INS)
             || (stat.command == tjpq_pkg::CMD_PRIO_INS)
             || (stat.command == tjpq_pkg::CMD_APPEND);
    is_pop    = (stat.command == tjpq_pkg::CMD_POP)
             || (stat.command == tjpq_pkg::CMD_POP_RET);
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (is_insert && stat.full) begin
          ctl.set_status = 1'b1;
          ctl.status_val = tjpq_pkg::ST_FULL;
          state_next     = S_DONE;
        end else if (is_insert && (stat.command == tjpq_pkg::CMD_APPEND)) begin
          ctl.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end else if (is_insert) begin
          ctl.search_init = 1'b1;
          state_next      = S_SEARCH;
        end else if (is_pop && stat.empty) begin
          ctl.set_status = 1'b1;
          ctl.status_val = tjpq_pkg::ST_EMPTY;
          state_next     = S_DONE;
        end else if (is_pop) begin
          ctl.pop_read = 1'b1;
          state_next   = S_POP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          ctl.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end else begin
          ctl.search_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = S_WRITE;
        end else begin
          ctl.shift_step = 1'b1;
        end
      end
      S_WRITE: begin
        ctl.write_new = 1'b1;
        state_next    = S_DONE;
      end
      S_POP: begin
        ctl.pop_commit = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/timed_job_priority_queue.sv =====
// Each accepted word goes from decode straight to the result for a reject or
//   an unused code, through pop for a pop, through shift and write for an
//   append, through search, shift and write for time or priority inserts.
// Words are taken one at a time, the next in the cycle after a result loads.
//   Search and shift walk one entry per cycle over the single RAM read port.
// Reset clears depth, byte total, new-job count and handshakes; the entry RAM
//   is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// timed_job_priority_queue - ordered job queue with timed and priority insert
// Controller plus datapath; entries are kept in order in a RAM ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_job_priority_queue #(
  parameter int QUEUE_DEPTH = tjpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tjpq_pkg::CMD_W-1:0]    command,
  input  wire logic [tjpq_pkg::TAG_W-1:0]    job_tag,
  input  wire logic [tjpq_pkg::PRI_W-1:0]    job_priority,
  input  wire logic [tjpq_pkg::SEC_W-1:0]    wake_sec,
  input  wire logic [tjpq_pkg::NSEC_W-1:0]   wake_nanosec,
  input  wire logic [tjpq_pkg::BYTES_W-1:0]  job_bytes,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tjpq_pkg::STAT_W-1:0]   status,
  output logic      [tjpq_pkg::TAG_W-1:0]    out_tag,
  output logic      [tjpq_pkg::PRI_W-1:0]    out_priority,
  output logic      [tjpq_pkg::SEC_W-1:0]    out_sec,
  output logic      [tjpq_pkg::NSEC_W-1:0]   out_nanosec,
  output logic      [tjpq_pkg::BYTES_W-1:0]  out_bytes,
  output logic      [tjpq_pkg::DEPTH_W-1:0]  queue_depth,
  output logic      [tjpq_pkg::TOTAL_W-1:0]  queue_bytes,
  output logic      [tjpq_pkg::NEW_W-1:0]    new_jobs
);

  tjpq_pkg::ctrl_cmd_t ctl;
  tjpq_pkg::dp_stat_t  stat;

  tjpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctl     (ctl)
  );

  tjpq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .command     (command),
    .job_tag     (job_tag),
    .job_priority(job_priority),
    .wake_sec    (wake_sec),
    .wake_nanosec(wake_nanosec),
    .job_bytes   (job_bytes),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .out_tag     (out_tag),
    .out_priority(out_priority),
    .out_sec     (out_sec),
    .out_nanosec (out_nanosec),
    .out_bytes   (out_bytes),
    .queue_depth (queue_depth),
    .queue_bytes (queue_bytes),
    .new_jobs    (new_jobs)
  );

  // one word in flight: no new word right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous word still in work");

  // failed commands report no popped job
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != tjpq_pkg::ST_OK) |-> (out_tag == '0) && (out_bytes == '0))
    else $error("popped fields set on a failed command");

  // an empty report only comes from an empty queue
  a_empty_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == tjpq_pkg::ST_EMPTY) |-> (queue_depth == '0))
    else $error("empty status with nonzero depth");

  // full and empty never together
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue flagged full and empty at once");

endmodule

`default_nettype wire

// ===== tb/sv/timed_job_priority_queue_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_job_priority_queue_chk - result checker for the timed job queue
// Watches both channels. Every accepted command word is applied to a shadow
// copy of the job queue; the report it yields is queued and compared field by
// field with the next accepted result word.
// ----------------------------------------------------------------------------

module timed_job_priority_queue_chk #(
  parameter int QUEUE_DEPTH = tjpq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [tjpq_pkg::CMD_W-1:0]     command,
  input  logic [tjpq_pkg::TAG_W-1:0]     job_tag,
  input  logic [tjpq_pkg::PRI_W-1:0]     job_priority,
  input  logic [tjpq_pkg::SEC_W-1:0]     wake_sec,
  input  logic [tjpq_pkg::NSEC_W-1:0]    wake_nanosec,
  input  logic [tjpq_pkg::BYTES_W-1:0]   job_bytes,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tjpq_pkg::STAT_W-1:0]    status,
  input  logic [tjpq_pkg::TAG_W-1:0]     out_tag,
  input  logic [tjpq_pkg::PRI_W-1:0]     out_priority,
  input  logic [tjpq_pkg::SEC_W-1:0]     out_sec,
  input  logic [tjpq_pkg::NSEC_W-1:0]    out_nanosec,
  input  logic [tjpq_pkg::BYTES_W-1:0]   out_bytes,
  input  logic [tjpq_pkg::DEPTH_W-1:0]   queue_depth,
  input  logic [tjpq_pkg::TOTAL_W-1:0]   queue_bytes,
  input  logic [tjpq_pkg::NEW_W-1:0]     new_jobs,
  output int                             report_backlog,
  output int                             fail_count
);

  import tjpq_pkg::*;

  // one status report as the block returns it
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TAG_W-1:0]   tag;
    logic [PRI_W-1:0]   prio;
    logic [SEC_W-1:0]   sec;
    logic [NSEC_W-1:0]  nsec;
    logic [BYTES_W-1:0] nbytes;
    logic [DEPTH_W-1:0] depth;
    logic [TOTAL_W-1:0] total;
    logic [NEW_W-1:0]   newj;
  } queue_report_t;

  // shadow state of the queue
  entry_t             shadow_jobs[$];
  logic [TOTAL_W-1:0] held_bytes;
  logic [NEW_W-1:0]   new_count;

  // reports owed by the block, oldest first
  queue_report_t      due_reports[$];
  queue_report_t      rep;
  int                 fail_tally = 0;

  initial begin
    report_backlog = 0;
    fail_count     = 0;
    held_bytes     = '0;
    new_count      = '0;
  end

  // strictly later wakeup than (sec, ns); nanoseconds compared as raw bits
  function automatic bit wakes_later(entry_t e, logic [SEC_W-1:0] sec,
                                     logic [NSEC_W-1:0] ns);
    return (e.sec > sec) || (e.sec == sec && e.nsec > ns);
  endfunction

  // apply one command word to the shadow queue, return the report it yields
  function automatic queue_report_t run_queue_cmd(
    logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag, logic [PRI_W-1:0] pri,
    logic [SEC_W-1:0] sec, logic [NSEC_W-1:0] ns, logic [BYTES_W-1:0] nb);
    queue_report_t r;
    entry_t        job;
    int            slot;
    int            n;
    bit            hit;
    r      = '0;
    r.status = ST_OK;
    job    = '{tag: tag, prio: pri, sec: sec, nsec: ns, nbytes: nb};
    n      = shadow_jobs.size();
    if (cmd == CMD_TIME_INS || cmd == CMD_PRIO_INS || cmd == CMD_APPEND) begin
      if (n >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // first entry that the new job goes ahead of; tail by default
        slot = n;
        if (cmd != CMD_APPEND) begin
          for (int k = 0; k < n; k++) begin
            if (cmd == CMD_TIME_INS)
              hit = wakes_later(shadow_jobs[k], sec, ns);
            else
              hit = (shadow_jobs[k].prio > pri) ||
                    (shadow_jobs[k].prio == pri && wakes_later(shadow_jobs[k], sec, ns));
            if (hit && slot == n) slot = k;
          end
        end
        shadow_jobs.insert(slot, job);
        held_bytes = held_bytes + TOTAL_W'(nb);
        if (cmd == CMD_PRIO_INS && new_count < QUEUE_DEPTH) new_count = new_count + 1'b1;
      end
    end else if (cmd == CMD_POP || cmd == CMD_POP_RET) begin
      if (n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        job        = shadow_jobs.pop_front();
        r.tag      = job.tag;
        r.prio     = job.prio;
        r.sec      = job.sec;
        r.nsec     = job.nsec;
        r.nbytes   = job.nbytes;
        held_bytes = held_bytes - TOTAL_W'(job.nbytes);
        if (cmd == CMD_POP_RET && new_count > 0) new_count = new_count - 1'b1;
      end
    end
    // spare codes fall through: status ok, nothing changes
    r.depth = DEPTH_W'(shadow_jobs.size());
    r.total = held_bytes;
    r.newj  = new_count;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_tally++;
    end
  endtask

  // result side first, then the new command word of the same edge
  always @(posedge clk) begin
    if (rst) begin
      shadow_jobs.delete();
      due_reports.delete();
      held_bytes = '0;
      new_count  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          $error("result word with no command outstanding: status %0d depth %0d",
                 status, queue_depth);
          fail_tally++;
        end else begin
          rep = due_reports.pop_front();
          check_field("status",       rep.status, status);
          check_field("out_tag",      rep.tag,    out_tag);
          check_field("out_priority", rep.prio,   out_priority);
          check_field("out_sec",      rep.sec,    out_sec);
          check_field("out_nanosec",  rep.nsec,   out_nanosec);
          check_field("out_bytes",    rep.nbytes, out_bytes);
          check_field("queue_depth",  rep.depth,  queue_depth);
          check_field("queue_bytes",  rep.total,  queue_bytes);
          check_field("new_jobs",     rep.newj,   new_jobs);
        end
      end
      if (in_valid && in_ready)
        due_reports.push_back(run_queue_cmd(command, job_tag, job_priority,
                                            wake_sec, wake_nanosec, job_bytes));
    end
    report_backlog <= due_reports.size();
    fail_count     <= fail_tally;
  end

endmodule

// ===== tb/sv/timed_job_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_job_priority_queue_tb - top level test of the timed job queue
// Directed corner words first, then random bursts that fill, drain and mix
// the queue, with random idling on both channels, one long result stall
// and a quiet tail. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------

module timed_job_priority_queue_tb;

  import tjpq_pkg::*;

  localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1730;
  localparam int QUIET_WORDS  = 200;
  localparam int HOLD_AT_WORD = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;

  // command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  // random burst flavors
  localparam int BURST_FILL  = 0;
  localparam int BURST_DRAIN = 1;
  localparam int BURST_MIXED = 2;
  localparam int BURST_PRIO  = 3;

  localparam logic [NSEC_W-1:0] NSEC_TOP = 30'd999_999_999;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     command;
  logic [TAG_W-1:0]     job_tag;
  logic [PRI_W-1:0]     job_priority;
  logic [SEC_W-1:0]     wake_sec;
  logic [NSEC_W-1:0]    wake_nanosec;
  logic [BYTES_W-1:0]   job_bytes;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    status;
  logic [TAG_W-1:0]     out_tag;
  logic [PRI_W-1:0]     out_priority;
  logic [SEC_W-1:0]     out_sec;
  logic [NSEC_W-1:0]    out_nanosec;
  logic [BYTES_W-1:0]   out_bytes;
  logic [DEPTH_W-1:0]   queue_depth;
  logic [TOTAL_W-1:0]   queue_bytes;
  logic [NEW_W-1:0]     new_jobs;

  int                   report_backlog;
  int                   fail_count;

  logic                 hold_off_req;
  logic                 quiet_tail;
  bit                   calm_burst;

  timed_job_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .job_tag(job_tag), .job_priority(job_priority),
    .wake_sec(wake_sec), .wake_nanosec(wake_nanosec), .job_bytes(job_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_tag(out_tag), .out_priority(out_priority),
    .out_sec(out_sec), .out_nanosec(out_nanosec), .out_bytes(out_bytes),
    .queue_depth(queue_depth), .queue_bytes(queue_bytes), .new_jobs(new_jobs)
  );

  timed_job_priority_queue_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .job_tag(job_tag), .job_priority(job_priority),
    .wake_sec(wake_sec), .wake_nanosec(wake_nanosec), .job_bytes(job_bytes),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_tag(out_tag), .out_priority(out_priority),
    .out_sec(out_sec), .out_nanosec(out_nanosec), .out_bytes(out_bytes),
    .queue_depth(queue_depth), .queue_bytes(queue_bytes), .new_jobs(new_jobs),
    .report_backlog(report_backlog), .fail_count(fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("timed_job_priority_queue_tb: done, errors");
    $finish;
  end

  // result side: random stalls, one long hold-off, always ready in the tail
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // offer one command word and hold it until taken; maybe idle after
  task automatic send_job(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                          input logic [PRI_W-1:0] pri, input logic [SEC_W-1:0] sec,
                          input logic [NSEC_W-1:0] ns, input logic [BYTES_W-1:0] nb);
    command      <= cmd;
    job_tag      <= tag;
    job_priority <= pri;
    wake_sec     <= sec;
    wake_nanosec <= ns;
    job_bytes    <= nb;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet_tail && !calm_burst && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int                 sent;
    int                 mode;
    int                 burst_len;
    int                 pick;
    bit                 heavy;
    logic [CMD_W-1:0]   cmd;
    logic [PRI_W-1:0]   pri;
    logic [SEC_W-1:0]   sec;
    logic [NSEC_W-1:0]  ns;
    logic [BYTES_W-1:0] nb;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    command      <= CMD_TIME_INS;
    job_tag      <= '0;
    job_priority <= '0;
    wake_sec     <= '0;
    wake_nanosec <= '0;
    job_bytes    <= '0;
    hold_off_req <= 1'b0;
    quiet_tail   <= 1'b0;
    calm_burst   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // pops on an empty queue, retire count stays at zero
    send_job(CMD_POP,     16'h1234, 8'h12, 32'h0, 30'h0, 16'h0);
    send_job(CMD_POP_RET, 16'h4321, 8'h21, 32'h0, 30'h0, 16'h0);
    // spare codes answer ok and change nothing
    send_job(CMD_SPARE_A, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 16'hFFFF);
    send_job(CMD_SPARE_B, 16'hAAAA, 8'h55, 32'h5555_AAAA, 30'h2AAA_AAAA, 16'h5555);
    send_job(CMD_SPARE_C, 16'h0000, 8'h00, 32'h0, 30'h0, 16'h0);
    // time inserts: extremes, nanoseconds above range, equal times stay in order
    send_job(CMD_TIME_INS, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 16'hFFFF);
    send_job(CMD_TIME_INS, 16'h0000, 8'h00, 32'h0, 30'h0, 16'h0000);
    send_job(CMD_TIME_INS, 16'h0101, 8'h40, 32'd5, NSEC_TOP, 16'h0001);
    send_job(CMD_TIME_INS, 16'h0102, 8'h40, 32'd5, NSEC_TOP, 16'h0002);
    // priority inserts: ties on priority and time, low and high extremes
    send_job(CMD_PRIO_INS, 16'h0201, 8'h00, 32'd5, 30'd0, 16'h0010);
    send_job(CMD_PRIO_INS, 16'h0202, 8'h00, 32'd5, 30'd0, 16'h0020);
    send_job(CMD_PRIO_INS, 16'h0203, 8'hFF, 32'd0, 30'd0, 16'h8000);
    send_job(CMD_APPEND,   16'h0301, 8'h07, 32'd0, 30'd1, 16'h7FFF);
    send_job(CMD_POP,      16'h0, 8'h0, 32'h0, 30'h0, 16'h0);
    send_job(CMD_POP_RET,  16'h0, 8'h0, 32'h0, 30'h0, 16'h0);
    // drain the rest, then pop once more on empty
    repeat (7) send_job(CMD_POP, 16'h0, 8'h0, 32'h0, 30'h0, 16'h0);

    // random bursts
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mode       = $urandom_range(BURST_FILL, BURST_PRIO);
      burst_len  = $urandom_range(8, 40);
      heavy      = ($urandom_range(0, 2) == 0);
      calm_burst = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        if (sent == HOLD_AT_WORD) hold_off_req <= 1'b1;
        if (sent == RANDOM_WORDS - QUIET_WORDS) quiet_tail <= 1'b1;

        // command by burst flavor, with a trickle of spare codes
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        end else begin
          case (mode)
            BURST_FILL: begin
              cmd = (pick < 87) ? CMD_W'($urandom_range(CMD_TIME_INS, CMD_APPEND))
                                : CMD_W'($urandom_range(CMD_POP, CMD_POP_RET));
            end
            BURST_DRAIN: begin
              cmd = (pick < 80) ? CMD_W'($urandom_range(CMD_POP, CMD_POP_RET))
                                : CMD_W'($urandom_range(CMD_TIME_INS, CMD_APPEND));
            end
            BURST_PRIO: begin
              cmd = (pick < 70) ? CMD_PRIO_INS : CMD_POP;
            end
            default: begin
              cmd = CMD_W'($urandom_range(CMD_TIME_INS, CMD_POP_RET));
            end
          endcase
        end

        // priority: ties, extremes or anything
        case ($urandom_range(0, 3))
          0:       pri = PRI_W'($urandom_range(0, 3));
          1:       pri = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
          default: pri = PRI_W'($urandom);
        endcase

        // seconds: half the time one of four close values so ties happen
        case ($urandom_range(0, 3))
          0, 1:    sec = SEC_W'($urandom_range(0, 3));
          2:       sec = SEC_W'($urandom);
          default: sec = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        endcase

        // nanoseconds: close values, legal range, raw 30 bits, extremes
        pick = $urandom_range(0, 99);
        if (pick < 40)      ns = NSEC_W'($urandom_range(0, 3));
        else if (pick < 70) ns = NSEC_W'($urandom_range(0, 999_999_999));
        else if (pick < 85) ns = NSEC_W'($urandom);
        else begin
          case ($urandom_range(0, 2))
            0:       ns = '0;
            1:       ns = NSEC_TOP;
            default: ns = 30'h3FFF_FFFF;
          endcase
        end

        // byte sizes: heavy bursts push the total to its top
        if (heavy)                           nb = 16'hFFFF;
        else if ($urandom_range(0, 4) == 0)  nb = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
        else                                 nb = BYTES_W'($urandom);

        send_job(cmd, TAG_W'($urandom), pri, sec, ns, nb);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // wait for every report, then a quiet stretch for strays
    @(posedge clk);
    while (report_backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("timed_job_priority_queue_tb: done, clean");
    end else begin
      $display("timed_job_priority_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
